// File: rtl/ffjs_pkg.sv
package ffjs_pkg;

	localparam int JOB_COUNT_DEF     = 32;
	localparam int MACHINE_COUNT_DEF = 32;
	localparam int HORIZON_SLOTS_DEF = 1024;
	localparam int STEPS_PER_JOB_DEF = 32;

	// one busy-map word covers this many slots
	localparam int WORD_BITS = 32;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_SCHED = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		RES_PLAIN = 2'd0,
		RES_OK    = 2'd1,
		RES_FAIL  = 2'd2
	} res_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_TBL,
		ST_DEC,
		ST_SCAN,
		ST_WR_CUR,
		ST_WR_PREV,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic tbl_rd;
		logic decide;
		logic scan_run;
		logic wr_cur;
		logic wr_prev;
		logic sweep;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic in_sched_ok;
		logic in_clear;
		logic dec_end;
		logic found;
		logic exhausted;
		logic need_prev;
		logic sweep_last;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/first_fit_job_shop_slot_scheduler.sv
// First-fit job shop slot scheduler. Send a request on s_axis (kind in tuser: load a table
// entry, schedule a job's next operation, or clear); exactly one result item comes back on
// m_axis per request. Requests are handled one at a time. After reset, and after every clear
// request, the busy map is swept one word per cycle, MACHINE_COUNT*HORIZON_SLOTS/32 words
// (1024 by default), with s_tready low. A schedule walks the machine's timeline one 32-slot
// busy-map word at a time, and writes one more word when the placed run crosses a word
// boundary. The walk is set by the single read port of the busy-map memory. A held result
// with m_tready low stalls the next request. HORIZON_SLOTS must be a power of two of
// at least 64. No fit within the horizon returns status 1 and changes nothing.
module first_fit_job_shop_slot_scheduler #(
	parameter int JOB_COUNT     = ffjs_pkg::JOB_COUNT_DEF,
	parameter int MACHINE_COUNT = ffjs_pkg::MACHINE_COUNT_DEF,
	parameter int HORIZON_SLOTS = ffjs_pkg::HORIZON_SLOTS_DEF,
	parameter int STEPS_PER_JOB = ffjs_pkg::STEPS_PER_JOB_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // job[4:0], step[9:5], machine_id[14:10], duration[19:15]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // machine_used[4:0], start_time[14:5], finish_time[24:15],
	                              // makespan[34:25]
	output logic [0:0]  m_tuser   // status[0]
);

	import ffjs_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic       status;
	logic [4:0] machine_used;
	logic [9:0] start_time, finish_time, makespan;

	ffjs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	ffjs_dp #(
		.JOB_COUNT(JOB_COUNT), .MACHINE_COUNT(MACHINE_COUNT),
		.HORIZON_SLOTS(HORIZON_SLOTS), .STEPS_PER_JOB(STEPS_PER_JOB)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(s_tuser), .job(s_tdata[4:0]), .step(s_tdata[9:5]),
		.machine_id(s_tdata[14:10]), .duration(s_tdata[19:15]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.status(status), .machine_used(machine_used), .start_time(start_time),
		.finish_time(finish_time), .makespan(makespan)
	);

	assign m_tdata = {5'd0, makespan, finish_time, start_time, machine_used};
	assign m_tuser = status;

endmodule

// File: rtl/ffjs_ram.sv
module ffjs_ram #(
	parameter int W = 8,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [W-1:0]  wd,
	input  logic [AW-1:0] ra,
	output logic [W-1:0]  rd
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd <= mem_q[ra];
	end

endmodule

// File: rtl/ffjs_ctrl.sv
module ffjs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ffjs_pkg::sts_t sts,
	output ffjs_pkg::cmd_t cmd
);

	import ffjs_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.in_clear) state_d = ST_CLEAR;
					else if (sts.in_sched_ok) state_d = ST_TBL;
					else state_d = ST_DONE;
				end
			end
			ST_TBL: state_d = ST_DEC;
			ST_DEC: state_d = sts.dec_end ? ST_DONE : ST_SCAN;
			ST_SCAN: begin
				if (sts.found) state_d = ST_WR_CUR;
				else if (sts.exhausted) state_d = ST_DONE;
			end
			ST_WR_CUR: state_d = sts.need_prev ? ST_WR_PREV : ST_DONE;
			ST_WR_PREV: state_d = ST_DONE;
			ST_CLEAR: begin
				if (sts.sweep_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: cmd.sweep = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ST_TBL: cmd.tbl_rd = 1'b1;
			ST_DEC: cmd.decide = 1'b1;
			ST_SCAN: cmd.scan_run = 1'b1;
			ST_WR_CUR: cmd.wr_cur = 1'b1;
			ST_WR_PREV: cmd.wr_prev = 1'b1;
			ST_CLEAR: cmd.sweep = 1'b1;
			ST_DONE: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// File: rtl/ffjs_dp.sv
module ffjs_dp #(
	parameter int JOB_COUNT     = ffjs_pkg::JOB_COUNT_DEF,
	parameter int MACHINE_COUNT = ffjs_pkg::MACHINE_COUNT_DEF,
	parameter int HORIZON_SLOTS = ffjs_pkg::HORIZON_SLOTS_DEF,
	parameter int STEPS_PER_JOB = ffjs_pkg::STEPS_PER_JOB_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ffjs_pkg::cmd_t cmd,
	output ffjs_pkg::sts_t sts,
	input  logic [1:0]     req_type,
	input  logic [4:0]     job,
	input  logic [4:0]     step,
	input  logic [4:0]     machine_id,
	input  logic [4:0]     duration,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           status,
	output logic [4:0]     machine_used,
	output logic [9:0]     start_time,
	output logic [9:0]     finish_time,
	output logic [9:0]     makespan
);

	import ffjs_pkg::*;

	localparam int JIW  = $clog2(JOB_COUNT);
	localparam int SW   = $clog2(STEPS_PER_JOB);
	localparam int TW   = $clog2(HORIZON_SLOTS);
	localparam int WPM  = HORIZON_SLOTS / WORD_BITS;
	localparam int WIB  = (WPM > 1) ? $clog2(WPM) : 1;
	localparam int NW   = MACHINE_COUNT * WPM;
	localparam int BAW  = $clog2(NW);
	localparam int TD   = JOB_COUNT * STEPS_PER_JOB;
	localparam int TAW  = $clog2(TD);
	localparam int MW   = $clog2(MACHINE_COUNT);

	// captured request
	logic [JIW-1:0] jidx_q;
	logic           job_ok;

	// per-job state
	logic [TW-1:0] fin_q  [JOB_COUNT];
	logic [SW-1:0] step_q [JOB_COUNT];
	logic [TW-1:0] longest_q;

	// operation table: {duration, machine}
	logic           tbl_we;
	logic [TAW-1:0] tbl_wa, tbl_ra;
	logic [9:0]     tbl_rd;
	logic [SW-1:0]  op_cur;

	assign job_ok = 32'(job) < JOB_COUNT;
	assign tbl_we = cmd.capture && req_t'(req_type) == REQ_LOAD && job_ok
		&& 32'(step) < STEPS_PER_JOB;
	assign tbl_wa = TAW'(32'(job) * STEPS_PER_JOB + 32'(step));
	assign op_cur = step_q[jidx_q];
	assign tbl_ra = TAW'(32'(jidx_q) * STEPS_PER_JOB + 32'(op_cur));

	ffjs_ram #(.W(10), .D(TD)) u_tbl (
		.clk(clk), .we(tbl_we), .wa(tbl_wa), .wd({duration, machine_id}),
		.ra(tbl_ra), .rd(tbl_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) jidx_q <= JIW'(job);
	end

	// table decode
	logic [4:0]  t_mach, t_dur;
	logic [TW:0] srch_start;
	logic        mach_bad, start_oob;

	assign t_mach     = tbl_rd[4:0];
	assign t_dur      = tbl_rd[9:5];
	assign mach_bad   = 32'(t_mach) >= MACHINE_COUNT;
	assign srch_start = (TW+1)'(fin_q[jidx_q]) + (TW+1)'(1);
	assign start_oob  = 32'(srch_start) >= HORIZON_SLOTS;

	// scan registers
	logic [4:0]      d_q;
	logic [4:0]      slo_q;
	logic [BAW-1:0]  base_q;
	logic [WIB:0]    rw_q;
	logic            pv_s1;
	logic [WIB-1:0]  ew_s1;
	logic            first_q;
	logic [31:0]     prev_view_q, prev_raw_q, cur_raw_q;
	logic [WIB-1:0]  ew_q;
	logic [63:0]     mask_q;
	logic [TW-1:0]   end_q;

	// busy map RAM
	logic           bm_we;
	logic [BAW-1:0] bm_wa, bm_ra, cc_q;
	logic [31:0]    bm_wd, bm_rd;

	assign bm_ra = base_q + BAW'(rw_q[WIB-1:0]);

	always_comb begin
		bm_we = 1'b0;
		bm_wa = cc_q;
		bm_wd = '0;
		if (cmd.sweep) begin
			bm_we = 1'b1;
		end else if (cmd.wr_cur) begin
			bm_we = 1'b1;
			bm_wa = base_q + BAW'(ew_q);
			bm_wd = cur_raw_q | mask_q[63:32];
		end else if (cmd.wr_prev) begin
			bm_we = 1'b1;
			bm_wa = base_q + BAW'(ew_q) - BAW'(1);
			bm_wd = prev_raw_q | mask_q[31:0];
		end
	end

	ffjs_ram #(.W(32), .D(NW)) u_busy (
		.clk(clk), .we(bm_we), .wa(bm_wa), .wd(bm_wd), .ra(bm_ra), .rd(bm_rd)
	);

	// window check: previous word below, current word above
	logic [31:0] cur_view, low_busy;
	logic [63:0] win_busy, dm64;
	logic [31:0] hit;
	logic [4:0]  hit_idx;
	logic        any_hit;
	logic [6:0]  hit_sh;

	assign low_busy = ~(32'hFFFF_FFFF << slo_q);
	assign cur_view = bm_rd | (first_q ? low_busy : 32'h0);
	assign win_busy = {cur_view, prev_view_q};
	assign dm64     = ~(64'hFFFF_FFFF_FFFF_FFFF << d_q);

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			hit[i] = (win_busy & (dm64 << (7'(i) + 7'd33 - 7'(d_q)))) == 64'h0;
		end
		hit_idx = '0;
		for (int i = 31; i >= 0; i--) begin
			if (hit[i]) hit_idx = 5'(i);
		end
	end

	assign any_hit = |hit;
	assign hit_sh  = 7'(hit_idx) + 7'd33 - 7'(d_q);

	assign sts.found     = pv_s1 && any_hit;
	assign sts.exhausted = pv_s1 && !any_hit && 32'(ew_s1) == WPM - 1;
	assign sts.need_prev = mask_q[31:0] != 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else if (cmd.scan_run && 32'(rw_q) < WPM) begin
			pv_s1 <= 1'b1;
		end else begin
			pv_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			d_q         <= t_dur;
			slo_q       <= srch_start[4:0];
			base_q      <= BAW'(32'(MW'(t_mach)) * WPM);
			rw_q        <= (WIB+1)'(srch_start >> 5);
			first_q     <= 1'b1;
			prev_view_q <= 32'hFFFF_FFFF;
		end
		if (cmd.scan_run) begin
			rw_q  <= rw_q + (WIB+1)'(1);
			ew_s1 <= rw_q[WIB-1:0];
			if (pv_s1) begin
				if (any_hit) begin
					ew_q      <= ew_s1;
					cur_raw_q <= bm_rd;
					mask_q    <= dm64 << hit_sh;
					end_q     <= TW'(32'(ew_s1) * WORD_BITS + 32'(hit_idx));
				end else begin
					first_q     <= 1'b0;
					prev_view_q <= cur_view;
					prev_raw_q  <= bm_rd;
				end
			end
		end
	end

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= '0;
		end else if (cmd.sweep) begin
			cc_q <= sts.sweep_last ? '0 : cc_q + BAW'(1);
		end
	end

	assign sts.sweep_last = cc_q == BAW'(NW - 1);

	// result registers
	res_t          res_q;
	logic [4:0]    rmach_q;
	logic [TW-1:0] rstart_q, rfin_q;
	logic          dec_fail, dec_zero;

	assign dec_fail = mach_bad || (t_dur != 5'd0 && start_oob);
	assign dec_zero = !mach_bad && t_dur == 5'd0;
	assign sts.dec_end = dec_fail || dec_zero;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_q    <= (req_t'(req_type) == REQ_SCHED && !job_ok) ? RES_FAIL : RES_PLAIN;
			rmach_q  <= '0;
			rstart_q <= '0;
			rfin_q   <= '0;
		end
		if (cmd.decide) begin
			rmach_q <= t_mach;
			if (dec_fail) begin
				res_q <= RES_FAIL;
			end else if (dec_zero) begin
				res_q    <= RES_OK;
				rstart_q <= fin_q[jidx_q];
				rfin_q   <= fin_q[jidx_q];
			end
		end
		if (sts.exhausted && cmd.scan_run) res_q <= RES_FAIL;
		if (cmd.wr_cur) begin
			res_q    <= RES_OK;
			rstart_q <= end_q - TW'(d_q) + TW'(1);
			rfin_q   <= end_q;
		end
	end

	// job state
	logic [SW-1:0] op_next;
	assign op_next = (32'(op_cur) == STEPS_PER_JOB - 1) ? '0 : op_cur + SW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < JOB_COUNT; j++) begin
				fin_q[j]  <= '0;
				step_q[j] <= '0;
			end
			longest_q <= '0;
		end else if (cmd.capture && req_t'(req_type) == REQ_CLEAR) begin
			for (int j = 0; j < JOB_COUNT; j++) begin
				fin_q[j]  <= '0;
				step_q[j] <= '0;
			end
			longest_q <= '0;
		end else if (cmd.decide && dec_zero) begin
			step_q[jidx_q] <= op_next;
		end else if (cmd.wr_cur) begin
			step_q[jidx_q] <= op_next;
			fin_q[jidx_q]  <= end_q;
			if (end_q > longest_q) longest_q <= end_q;
		end
	end

	assign sts.in_clear    = req_t'(req_type) == REQ_CLEAR;
	assign sts.in_sched_ok = req_t'(req_type) == REQ_SCHED && job_ok;

	// output register
	logic       ov_q;
	logic       st_q;
	logic [4:0] om_q;
	logic [9:0] os_q, of_q, ok_q;

	assign sts.out_free = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ok_q <= 10'(longest_q);
			case (res_q)
				RES_OK: begin
					st_q <= 1'b0;
					om_q <= rmach_q;
					os_q <= 10'(rstart_q);
					of_q <= 10'(rfin_q);
				end
				RES_FAIL: begin
					st_q <= 1'b1;
					om_q <= rmach_q;
					os_q <= '0;
					of_q <= '0;
				end
				default: begin
					st_q <= 1'b0;
					om_q <= '0;
					os_q <= '0;
					of_q <= '0;
				end
			endcase
		end
	end

	assign out_valid    = ov_q;
	assign status       = st_q;
	assign machine_used = om_q;
	assign start_time   = os_q;
	assign finish_time  = of_q;
	assign makespan     = ok_q;

endmodule

// File: verif/tb_first_fit_job_shop_slot_scheduler.sv
`timescale 1ns / 100ps

module tb_first_fit_job_shop_slot_scheduler;
	import ffjs_pkg::*;

	localparam int JOBS = 32;
	localparam int MACHS = 32;
	localparam int SLOTS = 1024;
	localparam int STEPS = 32;
	localparam int LOADED_JOBS = 4;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic       status;
		logic [4:0] machine_used;
		logic [9:0] start_time;
		logic [9:0] finish_time;
		logic [9:0] makespan;
	} sched_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;

	first_fit_job_shop_slot_scheduler DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// predictor state
	bit         slot_busy [MACHS][SLOTS];
	logic [9:0] finish_of [JOBS];
	logic [4:0] next_op_of [JOBS];
	logic [4:0] op_machine [JOBS*STEPS];
	logic [4:0] op_duration [JOBS*STEPS];
	logic [9:0] span_so_far;

	sched_result_t pending_results[$];
	int  failures;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_off;
	longint cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL first_fit_job_shop_slot_scheduler");
			$finish;
		end
	end

	function automatic void clear_schedule();
		foreach (slot_busy[m, s]) slot_busy[m][s] = 1'b0;
		foreach (finish_of[j]) begin
			finish_of[j] = '0;
			next_op_of[j] = '0;
		end
		span_so_far = '0;
	endfunction

	function automatic sched_result_t predict_request(req_t kind, logic [4:0] job,
			logic [4:0] stp, logic [4:0] mach, logic [4:0] dur);
		sched_result_t r;
		int base, d, cand, j;
		bit found;
		r = '0;
		case (kind)
			REQ_LOAD: begin
				op_machine[job*STEPS + stp] = mach;
				op_duration[job*STEPS + stp] = dur;
			end
			REQ_CLEAR: clear_schedule();
			REQ_SCHED: begin
				base = job*STEPS + next_op_of[job];
				r.machine_used = op_machine[base];
				d = op_duration[base];
				if (d == 0) begin
					r.start_time = finish_of[job];
					r.finish_time = finish_of[job];
					next_op_of[job] = next_op_of[job] + 5'd1;
				end else begin
					found = 1'b0;
					cand = finish_of[job] + 1;
					while (cand + d <= SLOTS && !found) begin
						for (j = cand; j < cand + d; j++)
							if (slot_busy[op_machine[base]][j]) break;
						if (j == cand + d) found = 1'b1;
						else cand = j + 1;
					end
					if (!found) begin
						r.status = 1'b1;
					end else begin
						for (j = cand; j < cand + d; j++) slot_busy[op_machine[base]][j] = 1'b1;
						finish_of[job] = 10'(cand + d - 1);
						next_op_of[job] = next_op_of[job] + 5'd1;
						if (finish_of[job] > span_so_far) span_so_far = finish_of[job];
						r.start_time = 10'(cand);
						r.finish_time = finish_of[job];
					end
				end
			end
			default: ;
		endcase
		r.makespan = span_so_far;
		return r;
	endfunction

	task automatic send_request(req_t kind, logic [4:0] job, logic [4:0] stp = 0,
			logic [4:0] mach = 0, logic [4:0] dur = 0);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		pending_results.push_back(predict_request(kind, job, stp, mach, dur));
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, dur, mach, stp, job};
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// receiver handshake
	always @(posedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		sched_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tuser[0], m_tdata[4:0], m_tdata[14:5], m_tdata[24:15], m_tdata[34:25]};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected st=%0d m=%0d s=%0d f=%0d span=%0d",
						$realtime, want.status, want.machine_used, want.start_time,
						want.finish_time, want.makespan);
					$display("%0t:          actual   st=%0d m=%0d s=%0d f=%0d span=%0d",
						$realtime, got.status, got.machine_used, got.start_time,
						got.finish_time, got.makespan);
					failures++;
				end
			end
		end
	end

	// loads a whole random table for one job
	task automatic load_job(int job, int max_dur);
		for (int s = 0; s < STEPS; s++)
			send_request(REQ_LOAD, 5'(job), 5'(s), 5'($urandom_range(MACHS-1)),
				5'($urandom_range(max_dur)));
	endtask

	task automatic test_directed();
		send_request(REQ_LOAD, 0, 0, 0, 31);
		send_request(REQ_LOAD, 0, 1, 31, 0);
		send_request(REQ_LOAD, 0, 2, 31, 1);
		send_request(REQ_LOAD, 31, 0, 31, 31);
		send_request(REQ_LOAD, 31, 31, 0, 1);
		send_request(REQ_NOP, 31, 31, 31, 31);
		send_request(REQ_SCHED, 0);   // long op on machine 0
		send_request(REQ_SCHED, 0);   // zero duration: finish unchanged
		send_request(REQ_SCHED, 0);
		send_request(REQ_SCHED, 31);
		send_request(REQ_LOAD, 1, 0, 0, 31);
		send_request(REQ_SCHED, 1);   // must skip around job 0's run
		send_request(REQ_CLEAR, 0);
		send_request(REQ_SCHED, 1);   // same op again, clear resets the step
		drain();
	endtask

	// fill one machine until no fit; steps wrap past the table end
	task automatic test_horizon_full();
		send_request(REQ_CLEAR, 0);
		for (int s = 0; s < STEPS; s++) send_request(REQ_LOAD, 2, 5'(s), 5, 31);
		for (int i = 0; i < 36; i++) send_request(REQ_SCHED, 2);
		drain();
	endtask

	task automatic test_random(int count, int sidle, int rstall);
		int k;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (k < 75) send_request(REQ_SCHED, 5'($urandom_range(LOADED_JOBS-1)));
			else if (k < 92) send_request(REQ_LOAD, 5'($urandom_range(JOBS-1)),
				5'($urandom_range(STEPS-1)), 5'($urandom_range(MACHS-1)),
				5'($urandom_range(31)));
			else if (k < 97) send_request(REQ_NOP, 5'($urandom), 5'($urandom),
				5'($urandom), 5'($urandom));
			else send_request(REQ_CLEAR, 5'($urandom));
		end
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				for (int i = 0; i < 20; i++)
					send_request(REQ_SCHED, 5'($urandom_range(LOADED_JOBS-1)));
				drain();
			end
		join
	endtask

	initial begin
		failures = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		clear_schedule();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_LOAD;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_horizon_full();
		for (int j = 0; j < LOADED_JOBS; j++) load_job(j, (j % 2 == 0) ? 31 : 6);
		drain();
		test_random(50, 0, 0);
		test_random(40, 88, 0);
		test_random(40, 0, 88);
		test_random(50, 29, 29);
		test_backpressure();
		if (failures == 0) $display("PASS first_fit_job_shop_slot_scheduler");
		else $display("FAIL first_fit_job_shop_slot_scheduler");
		$finish;
	end

endmodule
